>>> sv/ps2_mouse_init_sequencer_assert.svh
// ----------------------------------------------------------------------------
// ps2 mouse init sequencer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_INIT_SEQUENCER_ASSERT_SVH
`define PS2_MOUSE_INIT_SEQUENCER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define PS2MI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2mi check failed");

// next-cycle implication, clocked on clk, off while in reset
`define PS2MI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2mi check failed");

`endif

>>> sv/ps2mi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mi_pkg
// types and protocol constants of the ps/2 mouse init sequencer
// ----------------------------------------------------------------------------
package ps2mi_pkg;

    // bytes seen from the mouse
    localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
    localparam logic [7:0] BYTE_FAIL   = 8'hFC;
    localparam logic [7:0] BYTE_ACK    = 8'hFA;

    // host commands
    localparam logic [7:0] CMD_READ_ID = 8'hF2;
    localparam logic [7:0] CMD_RATE    = 8'hF3;
    localparam logic [7:0] CMD_ENABLE  = 8'hF4;
    localparam logic [7:0] CMD_RESET   = 8'hFF;

    // sample rate arguments
    localparam logic [7:0] RATE_200 = 8'd200;
    localparam logic [7:0] RATE_100 = 8'd100;
    localparam logic [7:0] RATE_80  = 8'd80;
    localparam logic [7:0] RATE_60  = 8'd60;

    // mouse ids
    localparam logic [7:0] ID_PLAIN    = 8'd0;
    localparam logic [7:0] ID_WHEEL    = 8'd3;
    localparam logic [7:0] ID_FIVE_BTN = 8'd4;

    // packet sizes
    localparam logic [2:0] PKT_SHORT = 3'd3;
    localparam logic [2:0] PKT_LONG  = 3'd4;

    // configuration register indexes
    localparam logic REG_REQUESTED_ID  = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0] REQUESTED_ID_RST  = 8'd4;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd255;

    // ready phase code as seen on phase_out
    localparam logic [4:0] PHASE_READY = 5'd16;

    // one tick item
    typedef struct packed {
        logic       powered;
        logic       restart;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } tick_t;

    // one result item
    typedef struct packed {
        logic       cmd_valid;
        logic [7:0] cmd_byte;
        logic       cmd_has_arg;
        logic [7:0] cmd_arg;
        logic       rx_taken;
        logic       flush_rx;
        logic       ready_res;
        logic [7:0] mouse_id_out;
        logic [2:0] packet_size;
        logic [4:0] phase_out;
    } result_t;

endpackage

>>> sv/ps2mi_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mi_core
// bring-up phase machine, watchdog and config registers; one step per tick
// ----------------------------------------------------------------------------
module ps2mi_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  ps2mi_pkg::tick_t   item,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output ps2mi_pkg::result_t res
);

    typedef enum logic [4:0] {
        PH_OFF       = 5'd0,
        PH_BAT       = 5'd1,
        PH_ID        = 5'd2,
        PH_K1        = 5'd3,
        PH_K1_ACK    = 5'd4,
        PH_K2        = 5'd5,
        PH_K2_ACK    = 5'd6,
        PH_K3        = 5'd7,
        PH_K3_ACK    = 5'd8,
        PH_REQ       = 5'd9,
        PH_REQ_ACK   = 5'd10,
        PH_GETID     = 5'd11,
        PH_RATE      = 5'd12,
        PH_RATE_ACK  = 5'd13,
        PH_ENABLE    = 5'd14,
        PH_ENA_ACK   = 5'd15,
        PH_READY     = 5'd16,
        PH_FAILED    = 5'd17,
        PH_RESET     = 5'd18,
        PH_RESET_ACK = 5'd19
    } phase_t;

    phase_t     phase_reg, phase_next;
    phase_t     expiry_reg, expiry_next;
    logic [7:0] wdog_reg, wdog_next;
    logic [7:0] det_id_reg, det_id_next;
    logic [7:0] req_id_reg;
    logic [7:0] timeout_reg;

    // one step of the sequencer
    always_comb
    begin
        phase_next  = phase_reg;
        expiry_next = expiry_reg;
        wdog_next   = wdog_reg;
        det_id_next = det_id_reg;
        res         = '0;

        if (item.restart)
        begin
            phase_next = PH_RESET;
        end

        if (!item.powered && phase_next != PH_OFF)
        begin
            // power loss
            res.flush_rx = 1'b1;
            phase_next   = PH_OFF;
            wdog_next    = '0;
        end
        else
        begin
            unique case (phase_next) inside
                PH_BAT:
                begin
                    if (item.rx_valid)
                    begin
                        res.rx_taken = 1'b1;
                        if (item.rx_byte == ps2mi_pkg::BYTE_BAT_OK)
                        begin
                            phase_next = PH_ID;
                            wdog_next  = timeout_reg;
                        end
                        else if (item.rx_byte == ps2mi_pkg::BYTE_FAIL)
                        begin
                            phase_next = PH_FAILED;
                            wdog_next  = '0;
                        end
                    end
                end
                PH_ID:
                begin
                    if (item.rx_valid)
                    begin
                        res.rx_taken = 1'b1;
                        if (item.rx_byte != ps2mi_pkg::ID_PLAIN)
                        begin
                            det_id_next = ps2mi_pkg::BYTE_FAIL;
                            phase_next  = PH_RESET;
                        end
                        else
                        begin
                            det_id_next = ps2mi_pkg::ID_PLAIN;
                            if (req_id_reg == ps2mi_pkg::ID_WHEEL ||
                                req_id_reg == ps2mi_pkg::ID_FIVE_BTN)
                            begin
                                phase_next = PH_K1;
                            end
                            else
                            begin
                                phase_next = PH_RATE;
                            end
                        end
                        wdog_next = timeout_reg;
                    end
                end
                PH_K1, PH_K2, PH_K3, PH_RATE:
                begin
                    res.cmd_valid   = 1'b1;
                    res.cmd_byte    = ps2mi_pkg::CMD_RATE;
                    res.cmd_has_arg = 1'b1;
                    if (phase_next == PH_K1)
                    begin
                        res.cmd_arg = ps2mi_pkg::RATE_200;
                    end
                    else if (phase_next == PH_K2)
                    begin
                        res.cmd_arg = (det_id_reg == ps2mi_pkg::ID_PLAIN) ?
                                      ps2mi_pkg::RATE_100 : ps2mi_pkg::RATE_200;
                    end
                    else if (phase_next == PH_K3)
                    begin
                        res.cmd_arg = ps2mi_pkg::RATE_80;
                    end
                    else
                    begin
                        res.cmd_arg = ps2mi_pkg::RATE_60;
                    end
                    phase_next = phase_t'(phase_next + 5'd1);
                    wdog_next  = timeout_reg;
                end
                PH_REQ:
                begin
                    res.cmd_valid = 1'b1;
                    res.cmd_byte  = ps2mi_pkg::CMD_READ_ID;
                    phase_next    = PH_REQ_ACK;
                    wdog_next     = timeout_reg;
                end
                PH_ENABLE:
                begin
                    res.cmd_valid = 1'b1;
                    res.cmd_byte  = ps2mi_pkg::CMD_ENABLE;
                    phase_next    = PH_ENA_ACK;
                    wdog_next     = timeout_reg;
                end
                PH_GETID:
                begin
                    // watchdog keeps running from the acknowledge; taking the id byte clears it
                    if (item.rx_valid)
                    begin
                        res.rx_taken = 1'b1;
                        det_id_next  = item.rx_byte;
                        if (item.rx_byte == ps2mi_pkg::ID_PLAIN ||
                            item.rx_byte == req_id_reg ||
                            det_id_reg == ps2mi_pkg::ID_WHEEL)
                        begin
                            phase_next = PH_RATE;
                        end
                        else
                        begin
                            phase_next = PH_K1;
                        end
                        wdog_next = '0;
                    end
                end
                PH_READY, PH_FAILED:
                begin
                    wdog_next = '0;
                end
                PH_RESET:
                begin
                    res.cmd_valid = 1'b1;
                    res.cmd_byte  = ps2mi_pkg::CMD_RESET;
                    phase_next    = PH_RESET_ACK;
                    expiry_next   = PH_RESET;
                    wdog_next     = timeout_reg;
                end
                PH_RESET_ACK:
                begin
                    if (item.rx_valid)
                    begin
                        res.rx_taken = 1'b1;
                        if (item.rx_byte == ps2mi_pkg::BYTE_ACK)
                        begin
                            phase_next   = PH_BAT;
                            res.flush_rx = 1'b1;
                            wdog_next    = timeout_reg;
                        end
                    end
                end
                PH_K1_ACK, PH_K2_ACK, PH_K3_ACK, PH_REQ_ACK, PH_RATE_ACK, PH_ENA_ACK:
                begin
                    if (item.rx_valid)
                    begin
                        res.rx_taken = 1'b1;
                        if (item.rx_byte == ps2mi_pkg::BYTE_ACK)
                        begin
                            phase_next = phase_t'(phase_next + 5'd1);
                            wdog_next  = timeout_reg;
                        end
                    end
                end
                default:
                begin
                    // off and unused codes: start up once powered
                    if (item.powered)
                    begin
                        phase_next  = PH_BAT;
                        expiry_next = PH_RESET;
                        wdog_next   = timeout_reg;
                    end
                    else
                    begin
                        phase_next = PH_OFF;
                    end
                end
            endcase

            // watchdog count down and expiry
            if (wdog_next != 8'd0)
            begin
                wdog_next = wdog_next - 8'd1;
                if (wdog_next == 8'd0)
                begin
                    phase_next = expiry_next;
                end
            end
        end

        res.ready_res    = (phase_next == PH_READY);
        res.mouse_id_out = det_id_next;
        res.packet_size  = (det_id_next == ps2mi_pkg::ID_PLAIN) ?
                           ps2mi_pkg::PKT_SHORT : ps2mi_pkg::PKT_LONG;
        res.phase_out    = phase_next;
    end

    // state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_OFF;
            expiry_reg  <= PH_OFF;
            wdog_reg    <= '0;
            det_id_reg  <= ps2mi_pkg::BYTE_FAIL;
            req_id_reg  <= ps2mi_pkg::REQUESTED_ID_RST;
            timeout_reg <= ps2mi_pkg::TIMEOUT_TICKS_RST;
        end
        else
        begin
            if (step_en)
            begin
                phase_reg  <= phase_next;
                expiry_reg <= expiry_next;
                wdog_reg   <= wdog_next;
                det_id_reg <= det_id_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ps2mi_pkg::REG_REQUESTED_ID:
                    begin
                        req_id_reg <= cfg_data;
                        phase_reg  <= PH_RESET;
                    end
                    ps2mi_pkg::REG_TIMEOUT_TICKS:
                    begin
                        timeout_reg <= cfg_data;
                    end
                    default:
                    begin
                        timeout_reg <= timeout_reg;
                    end
                endcase
            end
        end
    end

endmodule

>>> sv/ps2_mouse_init_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_init_sequencer
// Host-side PS/2 mouse bring-up sequencer. Each accepted tick transaction
// advances the phase machine by one step and yields exactly one result
// transaction with the command to send, the receive handshake, ready, the
// detected mouse id and the packet size. The block takes one tick per clock
// cycle unless out_stall holds a full result register; each tick passes from
// the input register through the combinational phase decode and watchdog
// update into the result register. The result register holds while out_stall
// is high and a new tick is still taken as long as the input register is
// empty or steps into a free or draining result register in the same cycle.
// Writing requested_id forces the device reset phase; both registers should
// be written only while no tick is in flight.
// ----------------------------------------------------------------------------
module ps2_mouse_init_sequencer
(
    input  logic       clk,
    input  logic       rst_n,

    // tick channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       powered,
    input  logic       restart,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,

    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       cmd_valid,
    output logic [7:0] cmd_byte,
    output logic       cmd_has_arg,
    output logic [7:0] cmd_arg,
    output logic       rx_taken,
    output logic       flush_rx,
    output logic       ready_res,
    output logic [7:0] mouse_id_out,
    output logic [2:0] packet_size,
    output logic [4:0] phase_out,

    // configuration write port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic               in_valid_reg;
    ps2mi_pkg::tick_t   in_item_reg;
    logic               out_valid_reg;
    ps2mi_pkg::result_t out_res_reg;
    ps2mi_pkg::result_t step_res;
    logic               step_en;

    // a held tick steps when the result register is free or draining
    assign step_en  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step_en;

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= '{powered:  powered,
                             restart:  restart,
                             rx_valid: rx_valid,
                             rx_byte:  rx_byte};
        end
    end

    // sequencer step
    ps2mi_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (in_item_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (step_res)
    );

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_res_reg <= step_res;
        end
    end

    // result ports
    assign out_valid    = out_valid_reg;
    assign cmd_valid    = out_res_reg.cmd_valid;
    assign cmd_byte     = out_res_reg.cmd_byte;
    assign cmd_has_arg  = out_res_reg.cmd_has_arg;
    assign cmd_arg      = out_res_reg.cmd_arg;
    assign rx_taken     = out_res_reg.rx_taken;
    assign flush_rx     = out_res_reg.flush_rx;
    assign ready_res    = out_res_reg.ready_res;
    assign mouse_id_out = out_res_reg.mouse_id_out;
    assign packet_size  = out_res_reg.packet_size;
    assign phase_out    = out_res_reg.phase_out;

endmodule

>>> sv/ps2mi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mi_checker
// port-level checks of the ps/2 mouse init sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "ps2_mouse_init_sequencer_assert.svh"

module ps2mi_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       cmd_valid,
    input logic [7:0] cmd_byte,
    input logic       cmd_has_arg,
    input logic [7:0] cmd_arg,
    input logic       ready_res,
    input logic [7:0] mouse_id_out,
    input logic [4:0] phase_out
);

    // an empty result register never backs up the tick channel
    `PS2MI_ASSERT_IMP(a_no_stall_when_empty, !out_valid, !in_stall)

    // a stalled result transaction holds its payload
    `PS2MI_ASSERT_NXT(a_stalled_result_holds, out_valid && out_stall,
        out_valid && $stable(phase_out) && $stable(cmd_byte) && $stable(mouse_id_out))

    // only the sample rate command carries an argument
    `PS2MI_ASSERT_IMP(a_arg_only_on_rate, out_valid && cmd_has_arg,
        cmd_valid && cmd_byte == ps2mi_pkg::CMD_RATE && cmd_arg != 8'd0)

    // ready flag agrees with the reported phase
    `PS2MI_ASSERT_IMP(a_ready_matches_phase, out_valid,
        ready_res == (phase_out == ps2mi_pkg::PHASE_READY))

endmodule

bind ps2_mouse_init_sequencer ps2mi_checker u_ps2mi_checker (.*);
